// ===== hdl/rmm_pkg.sv =====
// ----------------------------------------------------------------------------
// rmm_pkg
// Shared types and constants for the range min/max segment tree core.
// ----------------------------------------------------------------------------
package rmm_pkg;

   localparam int MaxElements = 1024;
   localparam int IdxW        = $clog2(MaxElements);
   localparam int NodeW       = IdxW + 1;
   localparam int CountW      = IdxW + 1;

   localparam logic [1:0] STATUS_OK    = 2'd0;
   localparam logic [1:0] STATUS_EMPTY = 2'd1;
   localparam logic [1:0] STATUS_RANGE = 2'd2;

   localparam logic OP_SWAP  = 1'b0;
   localparam logic OP_QUERY = 1'b1;

   localparam logic [0:0] REG_ELEMENT_COUNT = 1'b0;

   typedef struct packed {
      logic            op;
      logic [IdxW-1:0] first_index;
      logic [IdxW-1:0] second_index;
   } req_type;

   typedef struct packed {
      logic [IdxW-1:0] range_min;
      logic [IdxW-1:0] range_max;
      logic            exact_match;
      logic [1:0]      status;
   } rsp_type;

   // one tree entry: min and max side by side
   typedef struct packed {
      logic [IdxW-1:0] vmin;
      logic [IdxW-1:0] vmax;
   } node_type;

   // reset content of a node: the index range covered by that node
   function automatic node_type node_init(input logic [NodeW-1:0] k);
      node_type n;
      logic [NodeW-1:0] lo;
      logic [NodeW-1:0] hi;
      lo = k;
      hi = k;
      for (int i = 0; i < NodeW; i++) begin
         if (lo < NodeW'(MaxElements)) begin
            lo = {lo[NodeW-2:0], 1'b0};
            hi = {hi[NodeW-2:0], 1'b1};
         end
      end
      n.vmin = lo[IdxW-1:0];
      n.vmax = hi[IdxW-1:0];
      return n;
   endfunction

endpackage

// ===== hdl/rmm_tree_ram.sv =====
// ----------------------------------------------------------------------------
// rmm_tree_ram
// Single-port tree memory with a registered read.
// ----------------------------------------------------------------------------
module rmm_tree_ram
   import rmm_pkg::*;
(
   input  logic             clock,
   input  logic             wr_en,
   input  logic [NodeW-1:0] addr,
   input  node_type         wr_data,
   output node_type         rd_data
);

   node_type mem [2*MaxElements];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[addr] <= wr_data;
      end
      rd_data <= mem[addr];
   end

endmodule

// ===== hdl/range_min_max_tree_swap_core.sv =====
// ----------------------------------------------------------------------------
// range_min_max_tree_swap_core
// Segment tree over a permutation; swaps positions, answers range min/max.
// ----------------------------------------------------------------------------
//  channel | direction | handshake
//  req     | in        | req_valid / req_stall
//  rsp     | out       | rsp_valid / rsp_stall
//  csr     | in        | apb write/read, pready tied high
//
// after reset an init pass writes each of the 2048 tree entries with its index
// range (one entry a cycle); no transfer is taken on req until it ends.
// a query reads up to two nodes per level; a swap reads and writes both leaves,
// then on each path reads both children and writes the parent at every level.
// errors skip the tree. all accesses use the single tree memory port. results wait
// in an output register; a request is taken when idle and it is empty or transfers.
module range_min_max_tree_swap_core
   import rmm_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  req_type          req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output rsp_type          rsp_data,
   input  logic             psel,
   input  logic             penable,
   input  logic             pwrite,
   input  logic [0:0]       paddr,
   input  logic [31:0]      pwdata,
   output logic [31:0]      prdata,
   output logic             pready
);

   typedef enum logic [10:0] {
      S_INIT  = 11'b00000000001,
      S_IDLE  = 11'b00000000010,
      S_SRDA  = 11'b00000000100,
      S_SRDB  = 11'b00000001000,
      S_SWRA  = 11'b00000010000,
      S_SWRB  = 11'b00000100000,
      S_PRDL  = 11'b00001000000,
      S_PRDR  = 11'b00010000000,
      S_PWR   = 11'b00100000000,
      S_QSTEP = 11'b01000000000,
      S_QRD   = 11'b10000000000
   } state_type;

   state_type        state_ff, state_in;
   logic [NodeW:0]   ptr_ff, ptr_in;      // init counter / query l / repair node
   logic [NodeW:0]   rptr_ff, rptr_in;    // query r
   logic [NodeW:0]   rptr_dec;
   logic             pass_ff, pass_in;    // swap: second path
   logic             rside_ff, rside_in;  // query: reading the r node
   node_type         tmp_ff, tmp_in;
   logic [IdxW-1:0]  amin_ff, amin_in, amax_ff, amax_in;
   req_type          cur_ff, cur_in;
   logic [CountW-1:0] count_ff;
   logic             out_v_ff, out_v_in;
   rsp_type          out_ff, out_in;
   logic             mem_we;
   logic [NodeW-1:0] mem_addr;
   node_type         mem_wd, mem_rd;
   logic             out_free, acc_req;
   logic [CountW-1:0] limit;
   logic             bad;

   rmm_tree_ram u_ram (
      .clock  (clock),
      .wr_en  (mem_we),
      .addr   (mem_addr),
      .wr_data(mem_wd),
      .rd_data(mem_rd)
   );

   assign pready = 1'b1;
   assign prdata = 32'(count_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= CountW'(1024);
      end else if (psel && penable && pwrite && paddr == REG_ELEMENT_COUNT) begin
         count_ff <= pwdata[CountW-1:0];
      end
   end

   assign out_free  = !out_v_ff || !rsp_stall;
   assign req_stall = !(state_ff == S_IDLE && out_free);
   assign acc_req   = req_valid && !req_stall;
   assign rsp_valid = out_v_ff;
   assign rsp_data  = out_ff;
   assign limit = (count_ff > CountW'(MaxElements)) ? CountW'(MaxElements) : count_ff;
   assign bad = ({1'b0, req_data.first_index} >= limit) ||
                ({1'b0, req_data.second_index} >= limit);
   assign rptr_dec = rptr_ff - 1'b1;

   always_comb begin
      state_in = state_ff;
      ptr_in   = ptr_ff;
      rptr_in  = rptr_ff;
      pass_in  = pass_ff;
      rside_in = rside_ff;
      tmp_in   = tmp_ff;
      amin_in  = amin_ff;
      amax_in  = amax_ff;
      cur_in   = cur_ff;
      out_v_in = out_v_ff && rsp_stall;
      out_in   = out_ff;
      mem_we   = 1'b0;
      mem_addr = ptr_ff[NodeW-1:0];
      mem_wd   = tmp_ff;
      case (state_ff)
         S_INIT: begin
            mem_we = 1'b1;
            mem_wd = node_init(ptr_ff[NodeW-1:0]);
            ptr_in = ptr_ff + 1'b1;
            if (ptr_ff == (NodeW+1)'(2*MaxElements-1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            mem_addr = {1'b1, req_data.first_index};
            if (acc_req) begin
               cur_in = req_data;
               out_in = '0;
               if (bad) begin
                  out_in.status = STATUS_RANGE;
                  out_v_in = 1'b1;
               end else if (req_data.op == OP_SWAP) begin
                  state_in = S_SRDA;
               end else if (req_data.first_index > req_data.second_index) begin
                  out_in.status = STATUS_EMPTY;
                  out_v_in = 1'b1;
               end else begin
                  ptr_in   = {2'b01, req_data.first_index};
                  rptr_in  = {2'b01, req_data.second_index} + 1'b1;
                  amin_in  = '1;
                  amax_in  = '0;
                  state_in = S_QSTEP;
               end
            end
         end
         S_SRDA: begin
            // leaf a value arrives; read leaf b
            tmp_in   = mem_rd;
            mem_addr = {1'b1, cur_ff.second_index};
            state_in = S_SRDB;
         end
         S_SRDB: begin
            mem_we   = 1'b1;
            mem_addr = {1'b1, cur_ff.first_index};
            mem_wd   = mem_rd;
            state_in = S_SWRB;
         end
         S_SWRB: begin
            mem_we   = 1'b1;
            mem_addr = {1'b1, cur_ff.second_index};
            mem_wd   = tmp_ff;
            ptr_in   = {2'b01, cur_ff.first_index} >> 1;
            pass_in  = 1'b0;
            state_in = S_PRDL;
         end
         S_PRDL: begin
            mem_addr = {ptr_ff[NodeW-2:0], 1'b0};
            state_in = S_PRDR;
         end
         S_PRDR: begin
            mem_addr = {ptr_ff[NodeW-2:0], 1'b1};
            tmp_in   = mem_rd;
            state_in = S_PWR;
         end
         S_PWR: begin
            mem_we   = 1'b1;
            mem_addr = ptr_ff[NodeW-1:0];
            mem_wd.vmin = (mem_rd.vmin < tmp_ff.vmin) ? mem_rd.vmin : tmp_ff.vmin;
            mem_wd.vmax = (mem_rd.vmax > tmp_ff.vmax) ? mem_rd.vmax : tmp_ff.vmax;
            ptr_in = ptr_ff >> 1;
            state_in = S_PRDL;
            if (ptr_ff == (NodeW+1)'(1)) begin
               if (!pass_ff) begin
                  pass_in  = 1'b1;
                  ptr_in   = {2'b01, cur_ff.second_index} >> 1;
               end else begin
                  out_v_in = 1'b1;
                  state_in = S_IDLE;
               end
            end
         end
         S_SWRA: begin
            state_in = S_IDLE;
         end
         S_QSTEP: begin
            // decide which node of this level to fetch, or finish when l reaches r
            if (ptr_ff >= rptr_ff) begin
               out_in.range_min   = amin_ff;
               out_in.range_max   = amax_ff;
               out_in.exact_match = (amin_ff == cur_ff.first_index) &&
                                    (amax_ff == cur_ff.second_index);
               out_v_in = 1'b1;
               state_in = S_IDLE;
            end else if (ptr_ff[0]) begin
               mem_addr = ptr_ff[NodeW-1:0];
               ptr_in   = ptr_ff + 1'b1;
               rside_in = 1'b0;
               state_in = S_QRD;
            end else if (rptr_ff[0]) begin
               mem_addr = rptr_dec[NodeW-1:0];
               rptr_in  = rptr_dec;
               rside_in = 1'b1;
               state_in = S_QRD;
            end else begin
               ptr_in  = ptr_ff >> 1;
               rptr_in = rptr_ff >> 1;
            end
         end
         S_QRD: begin
            if (mem_rd.vmin < amin_ff) amin_in = mem_rd.vmin;
            if (mem_rd.vmax > amax_ff) amax_in = mem_rd.vmax;
            // the level is done after the r side is taken, or after l if r needs no read
            if (rside_ff || !rptr_ff[0]) begin
               ptr_in  = ptr_ff >> 1;
               rptr_in = rptr_ff >> 1;
            end
            state_in = S_QSTEP;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_INIT;
         ptr_ff   <= '0;
         out_v_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         ptr_ff   <= ptr_in;
         out_v_ff <= out_v_in;
      end
   end

   always_ff @(posedge clock) begin
      rptr_ff  <= rptr_in;
      pass_ff  <= pass_in;
      rside_ff <= rside_in;
      tmp_ff   <= tmp_in;
      amin_ff  <= amin_in;
      amax_ff  <= amax_in;
      cur_ff   <= cur_in;
      out_ff   <= out_in;
   end

endmodule

// ===== tb/testbench.sv =====
// ----------------------------------------------------------------------------
// range min/max segment tree testbench
// Drives swaps and range queries through the req channel, with random gaps
// and rsp stalls. A permutation tracker predicts every result, and the
// element count is reprogrammed between phases.
// ----------------------------------------------------------------------------
module testbench;
   import rmm_pkg::*;

   class perm_tracker;
      bit [IdxW-1:0]   pos_value [MaxElements];
      bit [CountW-1:0] element_count;
      rsp_type         pending [$];
      int              errors;
      int              swaps, queries, empties, ranges, exacts;

      function new();
         for (int i = 0; i < MaxElements; i++) pos_value[i] = IdxW'(i);
         element_count = CountW'(MaxElements);
      endfunction

      // compute the expected result of one accepted transfer
      function void note(req_type r);
         rsp_type     e;
         int unsigned limit;
         int unsigned lo;
         int unsigned hi;
         bit [IdxW-1:0] t;
         e = '0;
         limit = (element_count < MaxElements) ? element_count : MaxElements;
         if (r.first_index >= limit || r.second_index >= limit) begin
            e.status = STATUS_RANGE;
            ranges++;
         end else if (r.op == OP_SWAP) begin
            t = pos_value[r.first_index];
            pos_value[r.first_index] = pos_value[r.second_index];
            pos_value[r.second_index] = t;
            e.status = STATUS_OK;
            swaps++;
         end else if (r.first_index > r.second_index) begin
            e.status = STATUS_EMPTY;
            empties++;
         end else begin
            lo = MaxElements;
            hi = 0;
            for (int i = r.first_index; i <= r.second_index; i++) begin
               if (pos_value[i] < lo) lo = pos_value[i];
               if (pos_value[i] > hi) hi = pos_value[i];
            end
            e.range_min = IdxW'(lo);
            e.range_max = IdxW'(hi);
            e.exact_match = (lo == r.first_index && hi == r.second_index);
            e.status = STATUS_OK;
            if (e.exact_match) exacts++;
            queries++;
         end
         pending.push_back(e);
      endfunction

      function void check(rsp_type g);
         rsp_type e;
         if (pending.size() == 0) begin
            $error("result with nothing expected: %p", g);
            errors++;
            return;
         end
         e = pending.pop_front();
         if (g.range_min !== e.range_min) begin
            $error("range_min expected %0d got %0d", e.range_min, g.range_min);
            errors++;
         end
         if (g.range_max !== e.range_max) begin
            $error("range_max expected %0d got %0d", e.range_max, g.range_max);
            errors++;
         end
         if (g.exact_match !== e.exact_match) begin
            $error("exact_match expected %0d got %0d", e.exact_match, g.exact_match);
            errors++;
         end
         if (g.status !== e.status) begin
            $error("status expected %0d got %0d", e.status, g.status);
            errors++;
         end
      endfunction
   endclass

   localparam int CycleLimit = 1500000;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   req_type     req_data;
   logic        rsp_valid;
   logic        rsp_stall;
   rsp_type     rsp_data;
   logic        psel;
   logic        penable;
   logic        pwrite;
   logic [0:0]  paddr;
   logic [31:0] pwdata;
   logic [31:0] prdata;
   logic        pready;

   perm_tracker tracker;
   int          cycle_count;
   int          idle_pct;

   range_min_max_tree_swap_core dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   always begin
      clock = 1'b1;
      #4;
      clock = 1'b0;
      #4;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CycleLimit) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("Simulation FAILED");
         $finish;
      end
   end

   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(0, 99) < idle_pct);
   end

   // a transfer happens at the next rising edge if valid and not stalled
   always @(negedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) tracker.check(rsp_data);
   end

   task automatic send_item(input req_type r);
      if ($urandom_range(0, 99) < idle_pct) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= r;
      do @(negedge clock); while (req_stall);
      tracker.note(r);
      @(posedge clock);
   endtask

   task automatic send(input logic op, input int a, input int b);
      req_type r;
      r.op = op;
      r.first_index = IdxW'(a);
      r.second_index = IdxW'(b);
      send_item(r);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (tracker.pending.size() > 0) @(posedge clock);
      repeat (100) @(posedge clock);
   endtask

   task automatic write_count(input int value);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= REG_ELEMENT_COUNT;
      pwdata  <= value;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      tracker.element_count = value[CountW-1:0];
   endtask

   task automatic random_items(input int n);
      int unsigned limit;
      int unsigned a;
      int unsigned b;
      int unsigned t;
      req_type     r;
      limit = (tracker.element_count < MaxElements) ? tracker.element_count : MaxElements;
      for (int i = 0; i < n; i++) begin
         // a stretch with no idling on either side
         idle_pct = (i >= n / 3 && i < n / 2) ? 0 : 31;
         r.op = 1'($urandom_range(0, 1));
         if (limit == 0 || $urandom_range(0, 99) < 8) begin
            a = $urandom_range(0, MaxElements - 1);
            b = $urandom_range(0, MaxElements - 1);
         end else begin
            a = $urandom_range(0, limit - 1);
            b = ($urandom_range(0, 3) == 0) ? (a + $urandom_range(0, 8)) % limit
                                            : $urandom_range(0, limit - 1);
            if (r.op == OP_QUERY && a > b && $urandom_range(0, 99) < 85) begin
               t = a;
               a = b;
               b = t;
            end
         end
         r.first_index = IdxW'(a);
         r.second_index = IdxW'(b);
         send_item(r);
      end
      idle_pct = 31;
   endtask

   initial begin
      tracker     = new();
      cycle_count = 0;
      idle_pct    = 31;
      reset       = 1'b1;
      req_valid   = 1'b0;
      req_data    = '0;
      rsp_stall   = 1'b0;
      psel        = 1'b0;
      penable     = 1'b0;
      pwrite      = 1'b0;
      paddr       = '0;
      pwdata      = '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // directed: extremes, self swap, empty range, exact ranges
      send(OP_QUERY, 0, 1023);
      send(OP_QUERY, 0, 0);
      send(OP_QUERY, 1023, 1023);
      send(OP_QUERY, 5, 3);
      send(OP_QUERY, 1023, 0);
      send(OP_SWAP, 0, 1023);
      send(OP_QUERY, 0, 1022);
      send(OP_QUERY, 1, 1023);
      send(OP_QUERY, 0, 1023);
      send(OP_SWAP, 7, 7);
      send(OP_QUERY, 7, 7);
      send(OP_SWAP, 682, 341);
      send(OP_QUERY, 341, 682);
      send(OP_SWAP, 1023, 0);
      send(OP_QUERY, 0, 1023);
      drain();

      write_count(1);
      send(OP_QUERY, 0, 0);
      send(OP_SWAP, 0, 1);
      send(OP_QUERY, 1, 0);
      send(OP_SWAP, 1023, 1023);
      drain();
      write_count(0);
      send(OP_QUERY, 0, 0);
      send(OP_SWAP, 0, 0);
      drain();
      write_count(2047);
      send(OP_QUERY, 1023, 1023);
      send(OP_SWAP, 1022, 1023);
      drain();

      write_count(1024);
      random_items(600);
      drain();
      write_count(37);
      random_items(300);
      drain();
      write_count(2);
      random_items(100);
      drain();
      write_count(1);
      random_items(40);
      drain();
      write_count(2047);
      random_items(400);
      drain();
      write_count(513);
      random_items(400);
      drain();
      write_count(1024);
      random_items(20);
      drain();
      repeat (200) @(posedge clock);

      $display("covered %0d swaps, %0d ok queries (%0d exact), %0d empty, %0d out of range",
               tracker.swaps, tracker.queries, tracker.exacts, tracker.empties,
               tracker.ranges);
      $display("element counts 0, 1, 2, 37, 513, 1024 and 2047 in %0d cycles", cycle_count);
      if (tracker.errors == 0 && tracker.pending.size() == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
hdl/rmm_pkg.sv
hdl/rmm_tree_ram.sv
hdl/range_min_max_tree_swap_core.sv
tb/testbench.sv
